// ----- rtl/delimited_field_splitter_trim_core_defines.svh -----
// assertion macros used by the checker file
`ifndef DELIMITED_FIELD_SPLITTER_TRIM_CORE_DEFINES_SVH
`define DELIMITED_FIELD_SPLITTER_TRIM_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DFST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DFST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/dfst_pkg.sv -----
package dfst_pkg;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // register reset values
  localparam logic [7:0] SEP_RESET  = 8'd44;
  localparam logic       KEEP_RESET = 1'b0;

  // port widths
  localparam int BYTE_W      = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEPARATOR  = 1'b0,
    REG_KEEP_EMPTY = 1'b1
  } cfg_reg_t;

  // position within the current token
  typedef enum logic [1:0] {
    SCAN_BEGIN = 2'd0,
    SCAN_LEAD  = 2'd1,
    SCAN_TOKEN = 2'd2
  } scan_mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_SEND = 2'd2,
    ST_HOLD = 2'd3
  } ctrl_state_t;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_byte;
    logic              tok_close;
    logic              string_end;
    logic              overflow;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic out_from_in;
    logic hold_load;
    logic rd_en;
    logic out_from_rd;
    logic out_from_hold;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic produces_out;
    logic needs_flush;
    logic slot_free;
    logic last_rd;
  } dp_status_t;

  // whitespace dropped at the start of a token
  function automatic logic lead_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  // whitespace held back at the end of a token
  function automatic logic trail_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

endpackage

// ----- rtl/delimited_field_splitter_trim_core.sv -----
// results are registered; a result meeting a busy output slot waits in the hold slot
// throughput: one byte per cycle while no whitespace is held and out_tready stays high
// a byte releasing held whitespace waits in the hold slot while the held bytes pass the
//   single registered read port of the whitespace store (one read, one send per byte)
// reset: synchronous active-low rst_n clears token state, out_tvalid, separator
//   to 44 and empty-token mode to off; the whitespace store is not cleared
module delimited_field_splitter_trim_core #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] in_byte
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dfst_pkg::BYTE_W-1:0]      in_tdata,
  // out_tdata: [7:0] out_byte, [8] string_end, [9] pending_overflow, [15:10] zero
  // out_tuser: [0] has_byte
  // out_tlast: tok_close
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dfst_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [dfst_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dfst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dfst_pkg::dp_cmd_t    cmd;
  dfst_pkg::dp_status_t status;

  // token state, whitespace store and output register
  dfst_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status)
  );

  // sequencing of accept, flush and send
  dfst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

endmodule

// ----- rtl/dfst_ram.sv -----
module dfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dfst_datapath.sv -----
module dfst_datapath #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [dfst_pkg::BYTE_W-1:0]           in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [dfst_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [dfst_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dfst_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfst_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  dfst_pkg::dp_cmd_t                     cmd,
  output dfst_pkg::dp_status_t                  status
);

  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int ADDR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic [7:0]           sep_r, sep_nxt;
  logic                 keep_r, keep_nxt;
  dfst_pkg::scan_mode_t scan_r, scan_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 emitted_r, emitted_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dfst_pkg::result_t    out_r, out_nxt;
  dfst_pkg::result_t    hold_r, hold_nxt;
  dfst_pkg::result_t    in_res;
  dfst_pkg::result_t    rd_res;

  logic [7:0] c;
  logic       fire;
  logic       is_term, is_delim, in_tok, is_lead, is_trail, is_plain;
  logic       mark_te, has_room;
  logic       wr_en;
  logic [7:0] rd_data;

  // classify the offered byte
  always_comb begin
    c        = in_tdata;
    is_term  = (c == dfst_pkg::CHAR_NUL);
    is_delim = is_term || (c == sep_r);
    in_tok   = (scan_r == dfst_pkg::SCAN_TOKEN);
    is_lead  = !is_delim && !in_tok && dfst_pkg::lead_ws(c);
    is_trail = !is_delim && !is_lead && dfst_pkg::trail_ws(c);
    is_plain = !is_delim && !is_lead && !is_trail;
    mark_te  = (in_tok && emitted_r) || keep_r;
    has_room = (cnt_r < CNT_W'(PENDING_DEPTH));
  end

  // result caused directly by the offered byte
  always_comb begin
    in_res.data       = is_delim ? dfst_pkg::CHAR_NUL : c;
    in_res.has_byte   = !is_delim;
    in_res.tok_close  = is_delim && mark_te;
    in_res.string_end = is_delim && is_term;
    in_res.overflow   = is_delim && mark_te && ovf_r;
  end

  // held whitespace byte read back from the store
  always_comb begin
    rd_res.data       = rd_data;
    rd_res.has_byte   = 1'b1;
    rd_res.tok_close  = 1'b0;
    rd_res.string_end = 1'b0;
    rd_res.overflow   = 1'b0;
  end

  assign fire      = in_tvalid && cmd.in_ready;
  assign in_tready = cmd.in_ready;
  assign wr_en     = fire && is_trail && has_room;

  // status towards the controller
  always_comb begin
    status.in_valid     = in_tvalid;
    status.produces_out = is_delim ? (mark_te || is_term) : (is_plain && (cnt_r == '0));
    status.needs_flush  = is_plain && (cnt_r != '0);
    status.slot_free    = !out_valid_r || out_tready;
    status.last_rd      = (CNT_W'(rd_idx_r + 1'b1) == cnt_r);
  end

  // token state
  always_comb begin
    scan_nxt    = scan_r;
    cnt_nxt     = cnt_r;
    emitted_nxt = emitted_r;
    ovf_nxt     = ovf_r;
    if (fire) begin
      if (is_delim) begin
        scan_nxt    = dfst_pkg::SCAN_BEGIN;
        cnt_nxt     = '0;
        emitted_nxt = 1'b0;
        ovf_nxt     = 1'b0;
      end else if (is_lead) begin
        scan_nxt = dfst_pkg::SCAN_LEAD;
      end else begin
        scan_nxt = dfst_pkg::SCAN_TOKEN;
        if (is_trail) begin
          if (has_room) begin
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          emitted_nxt = 1'b1;
        end
      end
    end
    // store is empty once its last byte has gone out
    if (cmd.out_from_rd && status.last_rd) begin
      cnt_nxt = '0;
    end
  end

  // read pointer over the held bytes
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.hold_load) begin
      rd_idx_nxt = '0;
    end else if (cmd.out_from_rd) begin
      rd_idx_nxt = CNT_W'(rd_idx_r + 1'b1);
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    sep_nxt  = sep_r;
    keep_nxt = keep_r;
    if (cfg_valid) begin
      case (dfst_pkg::cfg_reg_t'(cfg_index))
        dfst_pkg::REG_SEPARATOR:  sep_nxt  = cfg_data[7:0];
        dfst_pkg::REG_KEEP_EMPTY: keep_nxt = cfg_data[0];
        default: begin
          sep_nxt  = sep_r;
          keep_nxt = keep_r;
        end
      endcase
    end
  end

  // hold slot and output register
  always_comb begin
    hold_nxt = cmd.hold_load ? in_res : hold_r;
    out_nxt  = out_r;
    if (cmd.out_from_in) begin
      out_nxt = in_res;
    end else if (cmd.out_from_rd) begin
      out_nxt = rd_res;
    end else if (cmd.out_from_hold) begin
      out_nxt = hold_r;
    end
    out_valid_nxt = (out_valid_r && !out_tready) ||
                    cmd.out_from_in || cmd.out_from_rd || cmd.out_from_hold;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= dfst_pkg::SEP_RESET;
      keep_r      <= dfst_pkg::KEEP_RESET;
      scan_r      <= dfst_pkg::SCAN_BEGIN;
      cnt_r       <= '0;
      emitted_r   <= 1'b0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sep_r       <= sep_nxt;
      keep_r      <= keep_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      emitted_r   <= emitted_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  // store of held trailing whitespace
  dfst_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (c),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // output ports
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dfst_pkg::OUT_TDATA_W - dfst_pkg::BYTE_W - 2){1'b0}},
                       out_r.overflow, out_r.string_end, out_r.data};
  assign out_tuser  = out_r.has_byte;
  assign out_tlast  = out_r.tok_close;

endmodule

// ----- rtl/dfst_ctrl.sv -----
module dfst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfst_pkg::dp_status_t status,
  output dfst_pkg::dp_cmd_t    cmd
);

  dfst_pkg::ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfst_pkg::ST_IDLE: begin
        if (status.in_valid) begin
          if (status.needs_flush) begin
            state_nxt = dfst_pkg::ST_READ;
          end else if (status.produces_out && !status.slot_free) begin
            state_nxt = dfst_pkg::ST_HOLD;
          end
        end
      end
      dfst_pkg::ST_READ: begin
        state_nxt = dfst_pkg::ST_SEND;
      end
      dfst_pkg::ST_SEND: begin
        if (status.slot_free) begin
          state_nxt = status.last_rd ? dfst_pkg::ST_HOLD : dfst_pkg::ST_READ;
        end
      end
      dfst_pkg::ST_HOLD: begin
        if (status.slot_free) begin
          state_nxt = dfst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dfst_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      dfst_pkg::ST_IDLE: begin
        cmd.in_ready    = 1'b1;
        cmd.out_from_in = status.in_valid && status.produces_out && status.slot_free;
        cmd.hold_load   = status.in_valid &&
                          (status.needs_flush || (status.produces_out && !status.slot_free));
      end
      dfst_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      dfst_pkg::ST_SEND: begin
        cmd.out_from_rd = status.slot_free;
      end
      dfst_pkg::ST_HOLD: begin
        cmd.out_from_hold = status.slot_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/dfst_checker.sv -----
`include "delimited_field_splitter_trim_core_defines.svh"

module dfst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dfst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [dfst_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                             out_tlast
);

  // a stalled result keeps its payload
  `DFST_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // marker results carry a zero byte
  `DFST_ASSERT_IMPL(a_marker_zero, out_tvalid && !out_tuser[0], out_tdata[7:0] == 8'h00)

  // token bytes carry no marker flags
  `DFST_ASSERT_IMPL(a_byte_no_flags, out_tvalid && out_tuser[0], !out_tlast && (out_tdata[9:8] == 2'b00))

  // overflow is only reported on a closing marker
  `DFST_ASSERT_IMPL(a_ovf_on_close, out_tvalid && out_tdata[9], out_tlast)

endmodule

bind delimited_field_splitter_trim_core dfst_checker u_dfst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
